// File: sv/constant_orientation_chain_unit_defines.svh
// assertion helpers shared by the chain unit
`ifndef CONSTANT_ORIENTATION_CHAIN_UNIT_DEFINES_SVH
`define CONSTANT_ORIENTATION_CHAIN_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define COC_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define COC_ASSERT_NXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/coc_pkg.sv
`timescale 1ns / 1ps

package coc_pkg;

    // default sizing
    localparam int COC_MAX_POINTS = 64;
    localparam int COC_COORD_BITS = 32;
    localparam int COC_FIELD_W    = 32;

    // orientation register reset value (right-handed)
    localparam logic [1:0] COC_MODE_RESET = 2'd1;

    // turn codes, compared against the orientation register
    typedef enum logic [1:0] {
        TURN_LEFT  = 2'd0,
        TURN_RIGHT = 2'd1,
        TURN_NONE  = 2'd2
    } coc_turn_t;

    // main sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_WAIT,
        S_PUSH,
        S_EMIT_RD,
        S_EMIT
    } coc_state_t;

    // cross product unit phases
    typedef enum logic [1:0] {
        XP_IDLE,
        XP_MUL_A,
        XP_MUL_B,
        XP_CMP
    } coc_xphase_t;

    // status from the cross product unit
    typedef struct packed {
        logic      done;
        coc_turn_t turn;
    } coc_cross_stat_t;

    // channel payloads
    typedef struct packed {
        logic signed [COC_FIELD_W-1:0] point_x;
        logic signed [COC_FIELD_W-1:0] point_y;
        logic                          end_of_curve;
    } coc_point_t;

    typedef struct packed {
        logic signed [COC_FIELD_W-1:0] kept_x;
        logic signed [COC_FIELD_W-1:0] kept_y;
        logic                          last_kept;
        logic                          capacity_overflow;
    } coc_kept_t;

    typedef struct packed {
        logic [1:0] orientation_mode;
    } coc_cfg_t;

endpackage

// File: sv/coc_stream_if.sv
`timescale 1ns / 1ps

// valid/ready channel carrying one request payload
interface coc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// File: sv/coc_chain_mem.sv
`timescale 1ns / 1ps

module coc_chain_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: sv/coc_cross_unit.sv
`timescale 1ns / 1ps

module coc_cross_unit
    import coc_pkg::*;
#(
    parameter int COORD_BITS = COC_COORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*COORD_BITS-1:0]   pt_a,
    input  logic [2*COORD_BITS-1:0]   pt_b,
    input  logic [COORD_BITS-1:0]     pt_cx,
    input  logic [COORD_BITS-1:0]     pt_cy,
    output coc_cross_stat_t           stat
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    coc_xphase_t phase_reg, phase_next;

    logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy;
    logic signed [DIFF_W-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [DIFF_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;

    // sign-extend coordinates to difference width
    assign ax = DIFF_W'($signed(pt_a[COORD_BITS-1:0]));
    assign ay = DIFF_W'($signed(pt_a[2*COORD_BITS-1:COORD_BITS]));
    assign bx = DIFF_W'($signed(pt_b[COORD_BITS-1:0]));
    assign by = DIFF_W'($signed(pt_b[2*COORD_BITS-1:COORD_BITS]));
    assign cx = DIFF_W'($signed(pt_cx));
    assign cy = DIFF_W'($signed(pt_cy));

    // phase sequencing
    always_comb
    begin
        case (phase_reg)
            XP_IDLE:  phase_next = start ? XP_MUL_A : XP_IDLE;
            XP_MUL_A: phase_next = XP_MUL_B;
            XP_MUL_B: phase_next = XP_CMP;
            XP_CMP:   phase_next = XP_IDLE;
            default:  phase_next = XP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= XP_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // shared multiplier, operands picked by phase
    always_comb
    begin
        op_a = (phase_reg == XP_MUL_B) ? d3_reg : d1_reg;
        op_b = (phase_reg == XP_MUL_B) ? d4_reg : d2_reg;
    end

    assign prod = PROD_W'(op_a) * PROD_W'(op_b);

    // difference and product registers
    always_ff @(posedge clk)
    begin
        if (phase_reg == XP_IDLE && start)
        begin
            d1_reg <= bx - ax;
            d2_reg <= cy - ay;
            d3_reg <= by - ay;
            d4_reg <= cx - ax;
        end
        if (phase_reg == XP_MUL_A)
        begin
            prod_a_reg <= prod;
        end
        if (phase_reg == XP_MUL_B)
        begin
            prod_b_reg <= prod;
        end
    end

    // sign of the cross product from the two products
    always_comb
    begin
        stat.done = (phase_reg == XP_CMP);
        if (prod_a_reg > prod_b_reg)
        begin
            stat.turn = TURN_RIGHT;
        end
        else if (prod_a_reg < prod_b_reg)
        begin
            stat.turn = TURN_LEFT;
        end
        else
        begin
            stat.turn = TURN_NONE;
        end
    end

endmodule

// File: sv/constant_orientation_chain_unit.sv
// Turn-consistent point chain over a polyline (convex-hull style stack filter).
// point_in takes one point per request: point_x, point_y (signed Q16.16) and
// end_of_curve. Before each push the stack top is popped while two or more
// points are held and the turn (second, top, new) differs from the mode in cfg.
// cfg is a valid/ready write of orientation_mode, always ready; write it only
// while the unit is idle. kept_out gives the stack bottom to top after the end
// point, last_kept on the final one and capacity_overflow if a point was dropped.
// A request is taken only in the idle state. Each turn test runs the
// shared cross product unit (one 33x33 multiplier used twice) through its
// multiply and compare phases. A point goes from check to push while fewer
// than two points are held; each turn test adds a fetch and a wait state,
// and a pop goes back to the check. Output alternates a read state and an
// emit state for each result, bound by the stack memory's registered read port.
// A stalled kept_out holds its result and the unit takes no new point until
// the whole curve has been taken. Reset clears the stack count, the overflow
// flag and the sequencer and sets orientation_mode to right-handed; the stack
// memory is not cleared, as only entries below the count are read.
`timescale 1ns / 1ps

module constant_orientation_chain_unit
    import coc_pkg::*;
#(
    parameter int MAX_POINTS = COC_MAX_POINTS,
    parameter int COORD_BITS = COC_COORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    coc_stream_if.sink         point_in,
    coc_stream_if.source       kept_out,
    coc_stream_if.sink         cfg
);

`include "constant_orientation_chain_unit_defines.svh"

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int PT_W  = 2 * COORD_BITS;

    coc_state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [1:0]            mode_reg;
    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic                  eoc_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      rd_addr_a, rd_addr_b;
    logic [PT_W-1:0]       rd_data_a, rd_data_b;
    logic                  cross_start;
    coc_cross_stat_t       cross_stat;
    logic                  full, last, mismatch;

    assign full     = (count_reg == CNT_W'(MAX_POINTS));
    assign last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign mismatch = (mode_reg != cross_stat.turn);

    // stack storage
    coc_chain_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (PT_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   (count_reg[IDX_W-1:0]),
        .wr_data   ({cy_reg, cx_reg}),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // turn test
    coc_cross_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cross_start),
        .pt_a  (rd_data_a),
        .pt_b  (rd_data_b),
        .pt_cx (cx_reg),
        .pt_cy (cy_reg),
        .stat  (cross_stat)
    );

    // read addresses: port a takes the second entry while testing and the emit index otherwise, port b the top
    always_comb
    begin
        rd_addr_a = (state_reg == S_CHECK) ? IDX_W'(count_reg - CNT_W'(2)) : idx_reg;
        rd_addr_b = IDX_W'(count_reg - CNT_W'(1));
    end

    // next state
    always_comb
    begin
        case (state_reg)
            S_IDLE:    state_next = point_in.valid ? S_CHECK : S_IDLE;
            S_CHECK:   state_next = (count_reg >= CNT_W'(2)) ? S_FETCH : S_PUSH;
            S_FETCH:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (!cross_stat.done)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = mismatch ? S_CHECK : S_PUSH;
                end
            end
            S_PUSH:    state_next = eoc_reg ? S_EMIT_RD : S_IDLE;
            S_EMIT_RD: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!kept_out.ready)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        point_in.ready = (state_reg == S_IDLE);
        kept_out.valid = (state_reg == S_EMIT);
        cross_start    = (state_reg == S_FETCH);
        mem_we         = (state_reg == S_PUSH) && !full;
        cfg.ready      = 1'b1;
    end

    // result payload straight from the registered read port
    always_comb
    begin
        kept_out.payload.kept_x            = COC_FIELD_W'($signed(rd_data_a[COORD_BITS-1:0]));
        kept_out.payload.kept_y            = COC_FIELD_W'($signed(rd_data_a[PT_W-1:COORD_BITS]));
        kept_out.payload.last_kept         = last;
        kept_out.payload.capacity_overflow = ovf_reg;
    end

    // stack count, overflow flag and emit index
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_WAIT:
            begin
                if (cross_stat.done && mismatch)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_PUSH:
            begin
                idx_next = '0;
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (kept_out.ready)
                begin
                    if (last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            mode_reg  <= COC_MODE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            if (cfg.valid)
            begin
                mode_reg <= cfg.payload.orientation_mode;
            end
        end
    end

    // capture of the incoming point
    always_ff @(posedge clk)
    begin
        if (point_in.valid && point_in.ready)
        begin
            cx_reg  <= point_in.payload.point_x[COORD_BITS-1:0];
            cy_reg  <= point_in.payload.point_y[COORD_BITS-1:0];
            eoc_reg <= point_in.payload.end_of_curve;
        end
    end

    // checks
    `COC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_POINTS), "stack count beyond capacity")
    `COC_ASSERT_IMP(a_no_overlap, clk, rst_n, point_in.ready, !kept_out.valid, "input taken while emitting")
    `COC_ASSERT_IMP(a_test_depth, clk, rst_n, cross_start, count_reg >= CNT_W'(2), "turn test with fewer than two points")
    `COC_ASSERT_NXT(a_clear_after_last, clk, rst_n, kept_out.valid && kept_out.ready && kept_out.payload.last_kept, count_reg == '0 && !ovf_reg, "stack not cleared after last result")

endmodule

// File: bench/constant_orientation_chain_unit_tb.sv
`timescale 1ns / 1ps

module constant_orientation_chain_unit_tb;
    import coc_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int IDLE_SETTLE  = 340;
    localparam int HOLD_CYCLES  = 400;
    localparam int POINT_BUDGET = 460;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES       = 7;

    // mode register values beyond the turn codes
    localparam int MODE_KEEP   = -1;
    localparam int MODE_UNUSED = 3;

    typedef enum int {
        CURVE_LINE,
        CURVE_ARC_RIGHT,
        CURVE_ARC_LEFT,
        CURVE_WALK,
        CURVE_WIDE,
        CURVE_EXTREME
    } curve_kind_t;

    typedef struct {
        int         mode_wr;
        coc_point_t pt;
        bit         typed;
        coc_kept_t  want;
    } chain_row_t;

    logic clk = 1'b0;
    logic rst_n;

    coc_stream_if #(.payload_t(coc_point_t)) point_if ();
    coc_stream_if #(.payload_t(coc_kept_t))  kept_if ();
    coc_stream_if #(.payload_t(coc_cfg_t))   cfg_if ();

    constant_orientation_chain_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .point_in (point_if),
        .kept_out (kept_if),
        .cfg      (cfg_if)
    );

    // shadow of the point stack
    logic signed [31:0] chain_x [COC_MAX_POINTS];
    logic signed [31:0] chain_y [COC_MAX_POINTS];
    int                 chain_depth;
    bit                 chain_dropped;
    logic [1:0]         orient_mode;
    coc_kept_t          chain_emit [$];
    coc_kept_t          kept_expect [$];

    int  fault_count   = 0;
    int  points_fed    = 0;
    int  cycle_count   = 0;
    int  gap_rate      = 0;
    bit  hold_kept_req = 1'b0;

    chain_row_t directed_rows [25];
    int phase_mode [PHASES] = '{TURN_NONE, TURN_LEFT, MODE_UNUSED, TURN_RIGHT,
                                TURN_NONE, TURN_LEFT, TURN_RIGHT};
    int phase_gap [PHASES]  = '{25, 0, 40, 10, 30, 15, 0};
    logic signed [31:0] extreme_vals [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                             32'hffff_ffff, 32'h0000_0001, 32'h8000_0001};

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact sign of the cross product over 68-bit integers
    function automatic coc_turn_t turn_of(input logic signed [31:0] ax, input logic signed [31:0] ay,
                                          input logic signed [31:0] bx, input logic signed [31:0] by,
                                          input logic signed [31:0] cx, input logic signed [31:0] cy);
        logic signed [67:0] wax, way, wbx, wby, wcx, wcy, cross_val;
        wax = 68'(ax);
        way = 68'(ay);
        wbx = 68'(bx);
        wby = 68'(by);
        wcx = 68'(cx);
        wcy = 68'(cy);
        cross_val = (wbx - wax) * (wcy - way) - (wby - way) * (wcx - wax);
        if (cross_val < 0)
            return TURN_LEFT;
        if (cross_val > 0)
            return TURN_RIGHT;
        return TURN_NONE;
    endfunction

    // pop, push and on the end point list the chain into chain_emit
    function automatic void advance_chain(input coc_point_t p);
        coc_kept_t r;
        chain_emit.delete();
        while (chain_depth >= 2 &&
               turn_of(chain_x[chain_depth-2], chain_y[chain_depth-2],
                       chain_x[chain_depth-1], chain_y[chain_depth-1],
                       p.point_x, p.point_y) != orient_mode)
            chain_depth--;
        if (chain_depth < COC_MAX_POINTS)
        begin
            chain_x[chain_depth] = p.point_x;
            chain_y[chain_depth] = p.point_y;
            chain_depth++;
        end
        else
            chain_dropped = 1'b1;
        if (p.end_of_curve)
        begin
            for (int k = 0; k < chain_depth; k++)
            begin
                r.kept_x            = chain_x[k];
                r.kept_y            = chain_y[k];
                r.last_kept         = (k == chain_depth - 1);
                r.capacity_overflow = chain_dropped;
                chain_emit = {chain_emit, r};
            end
            chain_depth   = 0;
            chain_dropped = 1'b0;
        end
    endfunction

    // directed row; a typed row is a one-point curve that comes back as is
    function automatic chain_row_t chain_row(input int mode_wr, input logic signed [31:0] x,
                                             input logic signed [31:0] y, input bit eoc,
                                             input bit typed);
        chain_row_t r;
        r.mode_wr = mode_wr;
        r.pt      = '{point_x: x, point_y: y, end_of_curve: eoc};
        r.typed   = typed;
        r.want    = '{kept_x: x, kept_y: y, last_kept: 1'b1, capacity_overflow: 1'b0};
        return r;
    endfunction

    // offer one point request, then book its expected kept points
    task automatic feed_point(input coc_point_t p, input bit typed, input coc_kept_t want);
        if (gap_rate != 0 && $urandom_range(0, 99) < gap_rate)
        begin
            point_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        point_if.valid   <= 1'b1;
        point_if.payload <= p;
        do
            @(posedge clk);
        while (!point_if.ready);
        advance_chain(p);
        if (typed)
            kept_expect = {kept_expect, want};
        else
            foreach (chain_emit[k])
                kept_expect = {kept_expect, chain_emit[k]};
        points_fed++;
    endtask

    // one curve of a given shape, end flag on its last point
    task automatic feed_curve(input curve_kind_t kind, input int len);
        logic signed [31:0] x0, y0, dx, dy, wx, wy, s;
        coc_point_t p;
        x0 = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        y0 = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        dx = $urandom_range(0, 2000) - 1000;
        dy = $urandom_range(0, 2000) - 1000;
        s  = $urandom_range(1, 4000);
        wx = x0;
        wy = y0;
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                CURVE_LINE:
                begin
                    p.point_x = x0 + k * dx;
                    p.point_y = y0 + k * dy;
                end
                CURVE_ARC_RIGHT:
                begin
                    p.point_x = x0 + k * s;
                    p.point_y = y0 + k * k * s;
                end
                CURVE_ARC_LEFT:
                begin
                    p.point_x = x0 + k * s;
                    p.point_y = y0 - k * k * s;
                end
                CURVE_WALK:
                begin
                    wx = wx + $urandom_range(0, 4) - 2;
                    wy = wy + $urandom_range(0, 4) - 2;
                    p.point_x = wx;
                    p.point_y = wy;
                end
                CURVE_WIDE:
                begin
                    p.point_x = $urandom;
                    p.point_y = $urandom;
                end
                default:
                begin
                    p.point_x = extreme_vals[$urandom_range(0, 5)];
                    p.point_y = extreme_vals[$urandom_range(0, 5)];
                end
            endcase
            p.end_of_curve = (k == len - 1);
            feed_point(p, 1'b0, '0);
        end
    endtask

    // let the unit go idle before touching the mode register
    task automatic wait_drained();
        point_if.valid <= 1'b0;
        while (kept_expect.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // mode register write request
    task automatic write_mode(input int m);
        cfg_if.payload <= '{orientation_mode: m[1:0]};
        cfg_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        orient_mode = m[1:0];
    endtask

    // kept output ready: random stalls plus the long hold-off on request
    initial
    begin : kept_drain
        int unsigned stall_left;
        stall_left    = 0;
        kept_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                kept_if.ready <= 1'b0;
            end
            else if (hold_kept_req)
            begin
                hold_kept_req = 1'b0;
                stall_left    = HOLD_CYCLES - 1;
                kept_if.ready <= 1'b0;
            end
            else if (gap_rate != 0 && $urandom_range(0, 99) < gap_rate)
            begin
                stall_left    = $urandom_range(0, 15);
                kept_if.ready <= 1'b0;
            end
            else
                kept_if.ready <= 1'b1;
        end
    end

    // compare each kept point against the oldest expectation
    always @(posedge clk)
    begin : kept_check
        coc_kept_t got, want;
        if (rst_n && kept_if.valid && kept_if.ready)
        begin
            got = kept_if.payload;
            if (kept_expect.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected kept point: x=%0d y=%0d last=%0b ovf=%0b",
                             got.kept_x, got.kept_y, got.last_kept, got.capacity_overflow);
            end
            else
            begin
                want = kept_expect.pop_front();
                if (got.kept_x !== want.kept_x || got.kept_y !== want.kept_y ||
                    got.last_kept !== want.last_kept ||
                    got.capacity_overflow !== want.capacity_overflow)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("kept point mismatch: expected x=%0d y=%0d last=%0b ovf=%0b, got x=%0d y=%0d last=%0b ovf=%0b",
                                 want.kept_x, want.kept_y, want.last_kept,
                                 want.capacity_overflow, got.kept_x, got.kept_y,
                                 got.last_kept, got.capacity_overflow);
                end
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("constant_orientation_chain_unit_tb: errors");
        $finish;
    end

    // stimulus
    initial
    begin
        int phase_start;
        int curve_idx;
        int budget;
        curve_kind_t kind;

        rst_n            = 1'b0;
        point_if.valid   = 1'b0;
        point_if.payload = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.payload   = '{orientation_mode: COC_MODE_RESET};
        orient_mode      = COC_MODE_RESET;
        chain_depth      = 0;
        chain_dropped    = 1'b0;

        directed_rows = '{
            // single points right after reset and at the field extremes
            chain_row(MODE_KEEP, 0, 0, 1'b1, 1'b1),
            chain_row(MODE_KEEP, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1),
            chain_row(MODE_KEEP, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1),
            chain_row(MODE_KEEP, -1, -1, 1'b1, 1'b1),
            // right turns kept under the reset mode
            chain_row(MODE_KEEP, 0, 0, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 1, 1, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 2, 4, 1'b1, 1'b0),
            // left turn pops the middle point
            chain_row(MODE_KEEP, 0, 0, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 2, 0, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 2, -2, 1'b1, 1'b0),
            // corner points, largest products
            chain_row(MODE_KEEP, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0),
            // left-handed mode
            chain_row(TURN_LEFT, 0, 0, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 4, 0, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 4, -4, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 8, -4, 1'b1, 1'b0),
            // collinear mode, off-line end point pops down to the first
            chain_row(TURN_NONE, 0, 0, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 3, 3, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 6, 6, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 1, 5, 1'b1, 1'b0),
            // unused mode matches no turn
            chain_row(MODE_UNUSED, 5, 5, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 6, 7, 1'b0, 1'b0),
            chain_row(MODE_KEEP, 9, 1, 1'b1, 1'b0)
        };

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        gap_rate = 20;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode_wr != MODE_KEEP)
            begin
                wait_drained();
                write_mode(directed_rows[i].mode_wr);
            end
            feed_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, one mode each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            write_mode(phase_mode[ph]);
            gap_rate    = phase_gap[ph];
            phase_start = points_fed;
            budget      = (POINT_BUDGET - points_fed) / (PHASES - ph);
            curve_idx   = 0;
            // long curves: overflow, overflow by one, exactly full
            if (ph == 0)
                feed_curve(CURVE_LINE, 66);
            else if (ph == 1)
                feed_curve(CURVE_ARC_LEFT, 65);
            else if (ph == 3)
                feed_curve(CURVE_ARC_RIGHT, COC_MAX_POINTS);
            while (points_fed - phase_start < budget)
            begin
                if ($urandom_range(0, 9) < 5)
                begin
                    case (phase_mode[ph])
                        TURN_LEFT:  kind = CURVE_ARC_LEFT;
                        TURN_RIGHT: kind = CURVE_ARC_RIGHT;
                        TURN_NONE:  kind = CURVE_LINE;
                        default:    kind = CURVE_WALK;
                    endcase
                end
                else
                    kind = curve_kind_t'($urandom_range(0, 5));
                feed_curve(kind, (curve_idx == 0) ? 8 : $urandom_range(1, 10));
                // hold kept output while the next curve keeps arriving
                if (curve_idx == 0 && (ph == 2 || ph == 4))
                    hold_kept_req = 1'b1;
                curve_idx++;
            end
        end

        // drain and finish
        gap_rate = 0;
        point_if.valid <= 1'b0;
        while (kept_expect.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
        if (fault_count == 0 && kept_expect.size() == 0)
            $display("constant_orientation_chain_unit_tb: clean");
        else
            $display("constant_orientation_chain_unit_tb: errors");
        $finish;
    end

endmodule
